// ===== rtl/mce_pkg.sv =====
// Package for the Morse keying encoder: payload types, symbol kinds,
// scale codes and the character-to-Morse table. Depends on nothing.
package mce_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIT_W    = 10;
  localparam int unsigned MS_W     = 12;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned PAT_W    = 7;
  localparam int unsigned MUL_W    = 3;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [DIT_W-1:0] DIT_RESET = 10'd100;
  localparam logic [DIT_W-1:0] DIT_MIN   = 10'd1;
  localparam logic [DIT_W-1:0] DIT_MAX   = 10'd1000;

  // Register index 0 holds the dit length.
  localparam logic REG_DIT = 1'b0;

  localparam logic [KIND_W-1:0] KIND_DIT        = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DAH        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LETTER_GAP = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WORD_GAP   = 2'd3;

  // Multiples of the dit length that the scaler can form.
  localparam logic [MUL_W-1:0] MUL_ZERO  = 3'd0;
  localparam logic [MUL_W-1:0] MUL_ONE   = 3'd1;
  localparam logic [MUL_W-1:0] MUL_TWO   = 3'd2;
  localparam logic [MUL_W-1:0] MUL_THREE = 3'd3;
  localparam logic [MUL_W-1:0] MUL_FOUR  = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] symbol_kind;
    logic [MS_W-1:0]   tone_ms;
    logic [MS_W-1:0]   gap_ms;
    logic              last;
  } out_item_t;

  // A length of zero means the character has no Morse code. The pattern is
  // left aligned: the first element sits in the top bit, and a one is a dah.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pat;
  } sym_t;

  function automatic sym_t lookup_sym(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] c;
    sym_t s;
    c = code;
    if (c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'd32;
    end
    unique case (c)
      "A":  s = '{3'd2, 7'b0100000};
      "B":  s = '{3'd4, 7'b1000000};
      "C":  s = '{3'd4, 7'b1010000};
      "D":  s = '{3'd3, 7'b1000000};
      "E":  s = '{3'd1, 7'b0000000};
      "F":  s = '{3'd4, 7'b0010000};
      "G":  s = '{3'd3, 7'b1100000};
      "H":  s = '{3'd4, 7'b0000000};
      "I":  s = '{3'd2, 7'b0000000};
      "J":  s = '{3'd4, 7'b0111000};
      "K":  s = '{3'd3, 7'b1010000};
      "L":  s = '{3'd4, 7'b0100000};
      "M":  s = '{3'd2, 7'b1100000};
      "N":  s = '{3'd2, 7'b1000000};
      "O":  s = '{3'd3, 7'b1110000};
      "P":  s = '{3'd4, 7'b0110000};
      "Q":  s = '{3'd4, 7'b1101000};
      "R":  s = '{3'd3, 7'b0100000};
      "S":  s = '{3'd3, 7'b0000000};
      "T":  s = '{3'd1, 7'b1000000};
      "U":  s = '{3'd3, 7'b0010000};
      "V":  s = '{3'd4, 7'b0001000};
      "W":  s = '{3'd3, 7'b0110000};
      "X":  s = '{3'd4, 7'b1001000};
      "Y":  s = '{3'd4, 7'b1011000};
      "Z":  s = '{3'd4, 7'b1100000};
      "0":  s = '{3'd5, 7'b1111100};
      "1":  s = '{3'd5, 7'b0111100};
      "2":  s = '{3'd5, 7'b0011100};
      "3":  s = '{3'd5, 7'b0001100};
      "4":  s = '{3'd5, 7'b0000100};
      "5":  s = '{3'd5, 7'b0000000};
      "6":  s = '{3'd5, 7'b1000000};
      "7":  s = '{3'd5, 7'b1100000};
      "8":  s = '{3'd5, 7'b1110000};
      "9":  s = '{3'd5, 7'b1111000};
      ".":  s = '{3'd6, 7'b0101010};
      ",":  s = '{3'd6, 7'b1100110};
      "?":  s = '{3'd6, 7'b0011000};
      "'":  s = '{3'd6, 7'b0111100};
      "!":  s = '{3'd6, 7'b1010110};
      "/":  s = '{3'd5, 7'b1001000};
      "(":  s = '{3'd5, 7'b1011000};
      ")":  s = '{3'd6, 7'b1011010};
      "&":  s = '{3'd5, 7'b0100000};
      ":":  s = '{3'd6, 7'b1110000};
      ";":  s = '{3'd6, 7'b1010100};
      "=":  s = '{3'd5, 7'b1000100};
      "+":  s = '{3'd5, 7'b0101000};
      "-":  s = '{3'd6, 7'b1000010};
      "_":  s = '{3'd6, 7'b0011010};
      "\"": s = '{3'd6, 7'b0100100};
      "$":  s = '{3'd7, 7'b0001001};
      "@":  s = '{3'd6, 7'b0110100};
      default: s = '{3'd0, 7'b0000000};
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/mce_in_if.sv =====
// Request channel carrying one character into the Morse encoder.
// Depends on mce_pkg for the payload type.
interface mce_in_if;
  import mce_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mce_out_if.sv =====
// Request channel carrying one keying command out of the Morse encoder.
// Depends on mce_pkg for the payload type.
interface mce_out_if;
  import mce_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mce_scale.sv =====
// Shared shift-and-add unit forming 0, 1, 2, 3 or 4 times the dit length.
// Depends on mce_pkg for widths and scale codes.
module mce_scale (
  input  logic [mce_pkg::DIT_W-1:0] dit,
  input  logic [mce_pkg::MUL_W-1:0] mult,
  output logic [mce_pkg::MS_W-1:0]  product
);
  import mce_pkg::*;

  logic [MS_W-1:0] shifted;
  logic [MS_W-1:0] addend;

  // The top two bits pick a shifted copy, the bottom bit adds one more dit.
  always_comb begin
    if (mult[2]) begin
      shifted = {dit, 2'b00};
    end else if (mult[1]) begin
      shifted = {1'b0, dit, 1'b0};
    end else begin
      shifted = '0;
    end
    addend  = mult[0] ? {2'b00, dit} : '0;
    product = shifted + addend;
  end

endmodule

// ===== rtl/morse_code_encoder.sv =====
// Morse keying encoder top level: APB register, sequencer and result register.
// Depends on mce_pkg, mce_in_if, mce_out_if and mce_scale.
//
// Usage. Each request on in_ch carries one character and an end-of-line
// flag. The block answers with a run of keying commands on out_ch: one dit
// or dah per Morse element followed by a letter gap, or a single word gap
// for a character outside the table, plus a word gap when end-of-line is
// set. The final command of a run has last high. Lower case is folded.
// Timing: in_ch.ready is high only while the sequencer is idle. Every
// command uses the single shift-and-add scaler twice (tone length, then
// gap length), and a character yields 1 to 9 commands, so the next
// request waits until the last one is loaded. When out_ch stalls, the
// finished command waits in the result register and the sequencer holds
// its place. The dit length is to be written over the APB port at byte
// address 0 while idle; the block itself does not enforce this. Zero is
// used as 1 and values above 1000 as 1000. Reset (rst_n low at a clock
// edge) sets the dit length to 100 ms, empties the result register and
// returns the sequencer to idle.
module morse_code_encoder (
  input  logic                       clk,
  input  logic                       rst_n,
  mce_in_if.sink                     in_ch,
  mce_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mce_pkg::CFG_AW-1:0] paddr,
  input  logic [mce_pkg::CFG_DW-1:0] pwdata,
  output logic [mce_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import mce_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ELEM = 3'd1;
  localparam logic [2:0] ST_LGAP = 3'd2;
  localparam logic [2:0] ST_WGAP = 3'd3;
  localparam logic [2:0] ST_EOL  = 3'd4;

  // Configuration register, kept raw so that a read returns the low DIT_W bits that were written.
  logic [DIT_W-1:0] dit_r;
  logic             cfg_wr;
  logic             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready && (cfg_idx == REG_DIT);
  assign prdata  = (cfg_idx == REG_DIT) ? {{(CFG_DW-DIT_W){1'b0}}, dit_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dit_r <= DIT_RESET;
    end else if (cfg_wr) begin
      dit_r <= pwdata[DIT_W-1:0];
    end
  end

  // Effective dit length, clamped into its legal range.
  logic [DIT_W-1:0] dit_eff;
  always_comb begin
    if (dit_r < DIT_MIN) begin
      dit_eff = DIT_MIN;
    end else if (dit_r > DIT_MAX) begin
      dit_eff = DIT_MAX;
    end else begin
      dit_eff = dit_r;
    end
  end

  // Sequencer state. cnt_r counts the elements still to send and pat_r
  // shifts left so that the current element is always in its top bit.
  logic [2:0]       state_r, state_nxt;
  logic             ph_r, ph_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [PAT_W-1:0] pat_r, pat_nxt;
  logic             eol_r, eol_nxt;
  logic [DIT_W-1:0] d_r, d_nxt;
  logic [MS_W-1:0]  tone_r, tone_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             in_take;
  logic             out_free;
  sym_t             sym;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign sym         = lookup_sym(in_ch.data.char_code);

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Description of the command that the current state produces.
  logic [KIND_W-1:0] cur_kind;
  logic [MUL_W-1:0]  tone_mul;
  logic [MUL_W-1:0]  gap_mul;
  logic              cur_last;

  always_comb begin
    unique case (state_r)
      ST_ELEM: begin
        cur_kind = pat_r[PAT_W-1] ? KIND_DAH : KIND_DIT;
        tone_mul = pat_r[PAT_W-1] ? MUL_THREE : MUL_ONE;
        gap_mul  = MUL_ONE;
        cur_last = 1'b0;
      end
      ST_LGAP: begin
        cur_kind = KIND_LETTER_GAP;
        tone_mul = MUL_ZERO;
        gap_mul  = MUL_TWO;
        cur_last = !eol_r;
      end
      ST_WGAP: begin
        cur_kind = KIND_WORD_GAP;
        tone_mul = MUL_ZERO;
        gap_mul  = MUL_FOUR;
        cur_last = !eol_r;
      end
      ST_EOL: begin
        cur_kind = KIND_WORD_GAP;
        tone_mul = MUL_ZERO;
        gap_mul  = MUL_FOUR;
        cur_last = 1'b1;
      end
      default: begin
        cur_kind = KIND_DIT;
        tone_mul = MUL_ZERO;
        gap_mul  = MUL_ZERO;
        cur_last = 1'b0;
      end
    endcase
  end

  // The one scaler serves the tone length in phase 0 and the gap in phase 1.
  logic [MS_W-1:0] scaled;

  mce_scale u_scale (
    .dit     (d_r),
    .mult    (ph_r ? gap_mul : tone_mul),
    .product (scaled)
  );

  logic emit;
  assign emit = (state_r != ST_IDLE) && ph_r && out_free;

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    cnt_nxt       = cnt_r;
    pat_nxt       = pat_r;
    eol_nxt       = eol_r;
    d_nxt         = d_r;
    tone_nxt      = tone_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_take) begin
      state_nxt = (sym.len == '0) ? ST_WGAP : ST_ELEM;
      ph_nxt    = 1'b0;
      cnt_nxt   = sym.len;
      pat_nxt   = sym.pat;
      eol_nxt   = in_ch.data.end_of_line;
      d_nxt     = dit_eff;
    end else if (state_r != ST_IDLE && !ph_r) begin
      tone_nxt = scaled;
      ph_nxt   = 1'b1;
    end else if (emit) begin
      out_nxt       = '{cur_kind, tone_r, scaled, cur_last};
      out_valid_nxt = 1'b1;
      ph_nxt        = 1'b0;
      unique case (state_r)
        ST_ELEM: begin
          cnt_nxt = cnt_r - 1'b1;
          pat_nxt = {pat_r[PAT_W-2:0], 1'b0};
          if (cnt_r == LEN_W'(1)) begin
            state_nxt = ST_LGAP;
          end
        end
        ST_LGAP, ST_WGAP: begin
          state_nxt = eol_r ? ST_EOL : ST_IDLE;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    pat_r  <= pat_nxt;
    eol_r  <= eol_nxt;
    d_r    <= d_nxt;
    tone_r <= tone_nxt;
    out_r  <= out_nxt;
  end

  // A character outside the table goes straight to its single word gap.
  a_unknown_to_wgap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && sym.len == '0) |=> (state_r == ST_WGAP))
    else $error("unknown character did not start a word gap");

  // The command marked last always returns the sequencer to idle.
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cur_last) |=> (state_r == ST_IDLE))
    else $error("sequencer kept running after the last command");

  // Element state never runs with an empty element count.
  a_elem_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ELEM) |-> (cnt_r != '0))
    else $error("element state with no elements left");

  // The latched dit length stays inside its legal range while busy.
  a_dit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (d_r >= DIT_MIN && d_r <= DIT_MAX))
    else $error("dit length out of range during a run");

  // A new command is only loaded once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !emit)
    else $error("result register overwritten while stalled");

endmodule
